@@ src/see_pkg.sv @@
// ----------------------------------------------------------------------------
// see_pkg
// Shared constants, codes and controller/datapath command types for the
// shannon entropy estimator.
// ----------------------------------------------------------------------------
package see_pkg;

  localparam int SYMBOL_SPACE_DEF  = 65536;
  localparam int COUNT_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;

  // log2 unit: Q31 mantissa, 24 fraction bits of result
  localparam int LOG_FRAC = 24;
  localparam int MANT_W   = 32;
  localparam int EXP_W    = 5;
  localparam int LOG_W    = EXP_W + LOG_FRAC;

  // sum of c*log2(c) and the divisor of the divider
  localparam int SUM_W  = 64;
  localparam int DIVR_W = 32;

  // result field widths
  localparam int BYTE_W = 8;
  localparam int SYM_W  = 16;
  localparam int MODE_W = 2;
  localparam int ENT_W  = 19;
  localparam int TOT_W  = 24;
  localparam logic [ENT_W-1:0] ENT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  // symbol_mode codes
  localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAIR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd2;

  // log base 8 is log2/3, log base 16 is log2/4
  localparam int BASE8_DIV  = 3;
  localparam int BASE16_DIV = 4;

  typedef struct packed {
    logic accept;      // byte taken, form symbol and read its bin
    logic bin_update;  // write back incremented bin, bump total
    logic clr_wr;      // clearing pass: zero bin at sweep address
    logic walk_clear;  // walk: zero bin just read, advance
    logic log_bin;     // start log2 of bin count
    logic log_tot;     // start log2 of symbol total
    logic mul;         // term = count * log2(count)
    logic acc;         // saturating add of term
    logic div_s;       // start sum / total
    logic div_e;       // latch rounded log difference for base scaling
    logic load_out;    // load result register
    logic clear_set;   // reset per-set state
  } see_cmd_t;

  typedef struct packed {
    logic last_flag;
    logic total_zero;
    logic addr_last;
    logic addr_wrapped;
    logic bin_nonzero;
    logic log_done;
    logic div_done;
    logic out_free;
  } see_sts_t;

endpackage

@@ src/see_in_if.sv @@
// ----------------------------------------------------------------------------
// see_in_if
// Byte stream channel: valid/ready with one data byte and a last marker.
// ----------------------------------------------------------------------------
interface see_in_if;
  logic                    valid;
  logic                    ready;
  logic [see_pkg::BYTE_W-1:0] data_byte;
  logic                    last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

@@ src/see_out_if.sv @@
// ----------------------------------------------------------------------------
// see_out_if
// Result channel: valid/ready with entropy, symbol count and flags.
// ----------------------------------------------------------------------------
interface see_out_if;
  logic                      valid;
  logic                      ready;
  logic [see_pkg::ENT_W-1:0] entropy_q16;
  logic [see_pkg::TOT_W-1:0] symbol_total;
  logic                      empty_res;
  logic                      overflow;

  modport source (output valid, output entropy_q16, output symbol_total,
                  output empty_res, output overflow, input ready);
  modport sink   (input valid, input entropy_q16, input symbol_total,
                  input empty_res, input overflow, output ready);
endinterface

@@ src/see_ram.sv @@
// ----------------------------------------------------------------------------
// see_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module see_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/see_log2.sv @@
// ----------------------------------------------------------------------------
// see_log2
// Iterative log2 in Q.24: normalize one bit a cycle, then one fraction bit
// a cycle by squaring the mantissa.
// ----------------------------------------------------------------------------
module see_log2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [see_pkg::MANT_W-1:0]  x,
  output logic                        busy,
  output logic                        done,
  output logic [see_pkg::LOG_W-1:0]   result
);
  import see_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_FRAC} lstate_t;

  localparam int STEP_W = $clog2(LOG_FRAC);

  lstate_t               state;
  logic [MANT_W-1:0]     mant;
  logic [EXP_W-1:0]      expo;
  logic [LOG_FRAC-1:0]   frac;
  logic [STEP_W-1:0]     step;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sq_top;

  assign sq     = mant * mant;
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];
  assign busy   = (state != L_IDLE);
  assign result = {expo, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            mant <= x;
            frac <= '0;
            step <= STEP_W'(LOG_FRAC - 1);
            if (x == '0) begin
              expo <= '0;
              done <= 1'b1;
            end else begin
              expo  <= EXP_W'(MANT_W - 1);
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (mant[MANT_W-1]) begin
            state <= L_FRAC;
          end else begin
            mant <= mant << 1;
            expo <= expo - 1'b1;
          end
        end
        L_FRAC: begin
          // square >= 2 gives a one bit and halves the mantissa
          frac <= {frac[LOG_FRAC-2:0], sq_top[MANT_W]};
          mant <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
          if (step == '0) begin
            state <= L_IDLE;
            done  <= 1'b1;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

@@ src/see_div.sv @@
// ----------------------------------------------------------------------------
// see_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend and
// 32-bit divisor.
// ----------------------------------------------------------------------------
module see_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [see_pkg::SUM_W-1:0]  dividend,
  input  logic [see_pkg::DIVR_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [see_pkg::SUM_W-1:0]  quotient
);
  import see_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  localparam int CNT_W = $clog2(SUM_W);

  dstate_t            state;
  logic [SUM_W-1:0]   quo;
  logic [DIVR_W-1:0]  rem;
  logic [DIVR_W-1:0]  dsr;
  logic [CNT_W-1:0]   cnt;
  logic [DIVR_W:0]    trial;
  logic [DIVR_W:0]    diff;
  logic               fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = (trial >= {1'b0, dsr});
  assign diff     = trial - {1'b0, dsr};
  assign busy     = (state != D_IDLE);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= dividend;
            rem   <= '0;
            dsr   <= divisor;
            cnt   <= CNT_W'(SUM_W - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          quo <= {quo[SUM_W-2:0], fits};
          rem <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
          if (cnt == '0) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

@@ src/see_datapath.sv @@
// ----------------------------------------------------------------------------
// see_datapath
// Histogram memory, pairing state, totals, log2 and divider units, sum of
// c*log2(c) and the result register.
// ----------------------------------------------------------------------------
module see_datapath #(
  parameter int SYMBOL_SPACE  = see_pkg::SYMBOL_SPACE_DEF,
  parameter int COUNT_BITS    = see_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = see_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [see_pkg::MODE_W-1:0]  cfg_wr_data,
  input  logic [see_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        last,
  input  see_pkg::see_cmd_t           cmd,
  output see_pkg::see_sts_t           sts,
  see_out_if.source                   result_ch
);
  import see_pkg::*;

  localparam int ADDR_W = $clog2(SYMBOL_SPACE);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int PROD_W = COUNT_BITS + LOG_W;
  // floor(x/3) = (x * RECIP3) >> 33 for any x below 2^32
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  logic [MODE_W-1:0]     mode;
  logic [BYTE_W-1:0]     prev_byte;
  logic                  have_prev;
  logic [COUNT_BITS-1:0] total;
  logic                  saturated;
  logic [ADDR_W-1:0]     sym_addr;
  logic                  sym_valid;
  logic                  last_flag;
  logic [ADDR_W-1:0]     addr_cnt;
  logic [COUNT_BITS-1:0] bin_cnt;
  logic [SUM_W-1:0]      term;
  logic [SUM_W-1:0]      sum;
  logic                  out_valid;
  logic [LOG_W:0]        t_reg;

  logic [SYM_W-1:0]      sym;
  logic                  sym_ok;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic                  bin_full;
  logic                  pair_mode;

  logic                  log_busy;
  logic                  log_done;
  logic [LOG_W-1:0]      log_res;
  logic [MANT_W-1:0]     log_x;

  logic                  div_busy;
  logic                  div_done;
  logic [SUM_W-1:0]      quot;
  logic [DIVR_W-1:0]     den;
  logic [LOG_W-1:0]      t_val;
  logic [LOG_W:0]        t_round;
  logic [LOG_W:0]        t_scaled;
  logic [LOG_W+32:0]     t_recip;
  logic [LOG_W:0]        ent_full;

  logic [PROD_W-1:0]     prod;
  logic [SUM_W:0]        sum_ext;
  logic [31:0]           total32;
  logic [ENT_W-1:0]      ent_val;
  logic [TOT_W-1:0]      tot_val;

  // symbol formed from the incoming byte under the current mode
  always_comb begin
    sym    = {{(SYM_W-BYTE_W){1'b0}}, data_byte};
    sym_ok = 1'b1;
    case (mode)
      MODE_PAIR: begin
        sym    = {data_byte, prev_byte};
        sym_ok = have_prev;
      end
      MODE_OVERLAP: begin
        sym    = {data_byte, prev_byte};
        sym_ok = have_prev;
      end
      default: begin
        sym    = {{(SYM_W-BYTE_W){1'b0}}, data_byte};
        sym_ok = 1'b1;
      end
    endcase
  end

  assign bin_full  = (rd_data == COUNT_MAX);
  assign ram_raddr = cmd.accept ? sym[ADDR_W-1:0] : addr_cnt;
  assign ram_we    = cmd.clr_wr | cmd.walk_clear |
                     (cmd.bin_update & sym_valid & ~bin_full);
  assign ram_waddr = cmd.bin_update ? sym_addr : addr_cnt;
  assign ram_wdata = cmd.bin_update ? rd_data + 1'b1 : '0;

  see_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SYMBOL_SPACE)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign log_x = cmd.log_bin ? MANT_W'(rd_data) : MANT_W'(total);

  see_log2 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_bin | cmd.log_tot),
    .x      (log_x),
    .busy   (log_busy),
    .done   (log_done),
    .result (log_res)
  );

  // t = log2(N) - S/N, clamped at zero, then rounded divide by 3 or 4 scaled
  assign pair_mode = (mode == MODE_PAIR) || (mode == MODE_OVERLAP);
  assign den       = pair_mode ? DIVR_W'(BASE16_DIV) << (LOG_FRAC - FRACTION_BITS)
                               : DIVR_W'(BASE8_DIV) << (LOG_FRAC - FRACTION_BITS);
  assign t_val     = (SUM_W'(log_res) > quot) ? log_res - quot[LOG_W-1:0] : '0;
  assign t_round   = {1'b0, t_val} + (LOG_W+1)'(den >> 1);

  see_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_s),
    .dividend (sum),
    .divisor  (DIVR_W'(total)),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // base 16 is a shift, base 8 a shift then a reciprocal multiply by 1/3
  assign t_scaled = t_reg >> (LOG_FRAC - FRACTION_BITS);
  assign t_recip  = (LOG_W+33)'(t_scaled) * (LOG_W+33)'(RECIP3);
  assign ent_full = pair_mode ?
                    (t_reg >> (LOG_FRAC - FRACTION_BITS + $clog2(BASE16_DIV))) :
                    {1'b0, t_recip[LOG_W+32:33]};

  assign prod    = bin_cnt * log_res;
  assign sum_ext = {1'b0, sum} + {1'b0, term};
  assign total32 = 32'(total);
  assign ent_val = (ent_full > (LOG_W+1)'(ENT_MAX)) ? ENT_MAX : ent_full[ENT_W-1:0];
  assign tot_val = (total32 > 32'(TOT_MAX)) ? TOT_MAX : total32[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SINGLE;
      prev_byte <= '0;
      have_prev <= 1'b0;
      total     <= '0;
      saturated <= 1'b0;
      sum       <= '0;
      addr_cnt  <= '0;
      sym_valid <= 1'b0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
      t_reg     <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (cmd.accept) begin
        sym_addr  <= sym[ADDR_W-1:0];
        last_flag <= last;
        case (mode)
          MODE_PAIR: begin
            sym_valid <= have_prev;
            prev_byte <= data_byte;
            have_prev <= ~have_prev;
          end
          MODE_OVERLAP: begin
            sym_valid <= have_prev;
            prev_byte <= data_byte;
            have_prev <= 1'b1;
          end
          default: begin
            sym_valid <= sym_ok;
          end
        endcase
      end
      if (cmd.bin_update && sym_valid) begin
        if (bin_full) begin
          saturated <= 1'b1;
        end
        if (total == COUNT_MAX) begin
          saturated <= 1'b1;
        end else begin
          total <= total + 1'b1;
        end
      end
      if (cmd.clr_wr || cmd.walk_clear) begin
        addr_cnt <= addr_cnt + 1'b1;
      end
      if (cmd.log_bin) begin
        bin_cnt <= rd_data;
      end
      if (cmd.mul) begin
        term <= SUM_W'(prod);
      end
      if (cmd.acc) begin
        sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
      if (cmd.div_e) begin
        t_reg <= t_round;
      end
      if (cmd.load_out) begin
        out_valid              <= 1'b1;
        result_ch.entropy_q16  <= (total == '0) ? '0 : ent_val;
        result_ch.symbol_total <= tot_val;
        result_ch.empty_res    <= (total == '0);
        result_ch.overflow     <= saturated;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear_set) begin
        prev_byte <= '0;
        have_prev <= 1'b0;
        total     <= '0;
        saturated <= 1'b0;
        sum       <= '0;
      end
    end
  end

  assign result_ch.valid = out_valid;

  assign sts.last_flag    = last_flag;
  assign sts.total_zero   = (total == '0);
  assign sts.addr_last    = (addr_cnt == ADDR_W'(SYMBOL_SPACE - 1));
  assign sts.addr_wrapped = (addr_cnt == '0);
  assign sts.bin_nonzero  = (rd_data != '0);
  assign sts.log_done     = log_done;
  assign sts.div_done     = div_done;
  assign sts.out_free     = ~out_valid | result_ch.ready;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || result_ch.ready))
    else $error("result loaded over an untaken result");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_set |=> (total == '0 && !saturated && !have_prev && sum == '0))
    else $error("per-set state not cleared after result");

  a_log_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.log_bin || cmd.log_tot) |-> !log_busy)
    else $error("log2 unit restarted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_s |-> !div_busy)
    else $error("divider restarted while busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && total == '0) |=>
      (result_ch.entropy_q16 == '0 && result_ch.empty_res))
    else $error("empty set gave nonzero entropy");

endmodule

@@ src/see_ctrl.sv @@
// ----------------------------------------------------------------------------
// see_ctrl
// Sequencer: clearing pass, byte read-modify-write, histogram walk, final
// log and divide, result hand-off.
// ----------------------------------------------------------------------------
module see_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  see_pkg::see_sts_t sts,
  output see_pkg::see_cmd_t cmd
);
  import see_pkg::*;

  typedef enum logic [3:0] {
    C_CLEAR, C_IDLE, C_BYTE, C_FIN, C_WRD, C_WDATA, C_LOGB,
    C_MUL, C_ACC, C_LOGN, C_DIVS, C_OUT
  } cstate_t;

  cstate_t state;
  cstate_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      C_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.addr_last) begin
          state_next = C_IDLE;
        end
      end
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = C_BYTE;
        end
      end
      C_BYTE: begin
        cmd.bin_update = 1'b1;
        state_next     = sts.last_flag ? C_FIN : C_IDLE;
      end
      C_FIN: begin
        state_next = sts.total_zero ? C_OUT : C_WRD;
      end
      C_WRD: begin
        state_next = C_WDATA;
      end
      C_WDATA: begin
        // every bin is zeroed as it is read
        cmd.walk_clear = 1'b1;
        if (sts.bin_nonzero) begin
          cmd.log_bin = 1'b1;
          state_next  = C_LOGB;
        end else if (sts.addr_last) begin
          cmd.log_tot = 1'b1;
          state_next  = C_LOGN;
        end else begin
          state_next = C_WRD;
        end
      end
      C_LOGB: begin
        if (sts.log_done) begin
          state_next = C_MUL;
        end
      end
      C_MUL: begin
        cmd.mul    = 1'b1;
        state_next = C_ACC;
      end
      C_ACC: begin
        cmd.acc = 1'b1;
        if (sts.addr_wrapped) begin
          cmd.log_tot = 1'b1;
          state_next  = C_LOGN;
        end else begin
          state_next = C_WRD;
        end
      end
      C_LOGN: begin
        if (sts.log_done) begin
          cmd.div_s  = 1'b1;
          state_next = C_DIVS;
        end
      end
      C_DIVS: begin
        if (sts.div_done) begin
          cmd.div_e  = 1'b1;
          state_next = C_OUT;
        end
      end
      C_OUT: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.clear_set = 1'b1;
          state_next    = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/shannon_entropy_estimator_top.sv @@
// ----------------------------------------------------------------------------
// shannon_entropy_estimator_top
// Byte-stream symbol histogram with entropy readout on the last byte.
// ----------------------------------------------------------------------------
// After reset the histogram RAM is swept to zero, during which no byte is
// taken. A byte then reads its bin in the histogram RAM and writes it back
// incremented. On the last byte the histogram is walked and zeroed bin by
// bin; each nonzero bin goes through the log2 unit (normalize plus 24
// squaring steps), then a multiply and an add. The log2 of the total and one
// divide of the sum by the total follow, then the scaling to the log base (a
// shift, or a shift and a reciprocal multiply by 1/3) and the result is
// registered. An empty set skips the walk. Bytes of the next set are taken
// while the result waits on the output. SYMBOL_SPACE must be a power of two.
module shannon_entropy_estimator_top #(
  parameter int SYMBOL_SPACE  = see_pkg::SYMBOL_SPACE_DEF,
  parameter int COUNT_BITS    = see_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = see_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [see_pkg::MODE_W-1:0] cfg_wr_data,
  see_in_if.sink                     data_ch,
  see_out_if.source                  result_ch
);
  import see_pkg::*;

  see_cmd_t cmd;
  see_sts_t sts;
  logic     in_ready;

  see_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  see_datapath #(
    .SYMBOL_SPACE  (SYMBOL_SPACE),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (data_ch.data_byte),
    .last        (data_ch.last),
    .cmd         (cmd),
    .sts         (sts),
    .result_ch   (result_ch)
  );

  assign data_ch.ready = in_ready;

endmodule
